### hw/rtl/dpr_pkg.sv
// ----------------------------------------------------------------------------
// dpr_pkg: shared definitions for the debug packet receiver
// Framing characters, result kinds, the result word type and the hex decoder.
// ----------------------------------------------------------------------------
package dpr_pkg;

    // Framing and reply characters
    localparam logic [7:0] CH_START = 8'h24;   // '$'
    localparam logic [7:0] CH_END   = 8'h23;   // '#'
    localparam logic [7:0] CH_COLON = 8'h3A;   // ':'
    localparam logic [7:0] CH_ACK   = 8'h2B;   // '+'
    localparam logic [7:0] CH_NAK   = 8'h2D;   // '-'

    // Result kinds carried on tuser
    localparam logic [2:0] KIND_PAYLOAD = 3'd0;
    localparam logic [2:0] KIND_REPLY   = 3'd1;
    localparam logic [2:0] KIND_ACCEPT  = 3'd2;
    localparam logic [2:0] KIND_DROP    = 3'd3;
    localparam logic [2:0] KIND_REJECT  = 3'd4;

    // Payload offset reported on accept when a sequence ID is present
    localparam logic [7:0] SEQ_OFFSET = 8'd3;

    // Most results one received byte can cause
    localparam int unsigned MAX_RESULTS = 4;

    // Register address map (word index)
    localparam logic REG_MAX_PAYLOAD = 1'b0;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] value;
        logic       last;
    } res_t;

    // Hex digit to nibble; anything else is -1 (0xFF) as in C
    function automatic logic [7:0] hex_digit(input logic [7:0] c);
        logic [7:0] d;
        if (c >= 8'h30 && c <= 8'h39)
            d = c - 8'h30;
        else if (c >= 8'h61 && c <= 8'h66)
            d = c - 8'h61 + 8'd10;
        else if (c >= 8'h41 && c <= 8'h46)
            d = c - 8'h41 + 8'd10;
        else
            d = 8'hFF;
        return d;
    endfunction

endpackage

### hw/rtl/debug_packet_receiver_unit.sv
// ----------------------------------------------------------------------------
// debug_packet_receiver_unit: $<payload>#<hh> packet receiver
// Hunts for '$', streams payload bytes out, checks the modulo-256 checksum
// and produces the '+'/'-' reply, sequence ID echo and status words.
// ----------------------------------------------------------------------------
// Result words: the first word of a byte is registered and valid in the
// cycle after the byte is accepted. One byte per cycle while each byte
// yields at most one word and m_tready is high; a byte yielding more words
// (up to 4) holds the result buffer until its last word has left.
// Reset: rst_n (async, active low) returns to hunting, clears the sums and
// the result buffer, and sets max_payload to 4095.
// ----------------------------------------------------------------------------
module debug_packet_receiver_unit #(
    parameter int BUFFER_BYTES = 4096
) (
    input  logic        clk,
    input  logic        rst_n,

    // Received byte stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [7:0] rx_byte

    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,     // [7:0] value
    output logic [2:0]  m_tuser,     // [2:0] kind
    output logic        m_tlast,

    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Limit cap, held to the 12-bit count range
    localparam logic [11:0] CAP = (BUFFER_BYTES - 1 > 4095) ? 12'hFFF
                                                            : 12'(BUFFER_BYTES - 1);

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_DATA = 2'd1,
        PH_HIGH = 2'd2,
        PH_LOW  = 2'd3
    } phase_t;

    phase_t             phase_reg,  phase_next;
    logic [7:0]         sum_reg,    sum_next;
    logic [11:0]        count_reg,  count_next;
    logic [15:0]        seq_reg,    seq_next;
    logic               colon_reg,  colon_next;
    logic [7:0]         high_reg,   high_next;
    logic [11:0]        max_payload_reg;

    dpr_pkg::res_t      buf_reg  [dpr_pkg::MAX_RESULTS];
    dpr_pkg::res_t      list_next[dpr_pkg::MAX_RESULTS];
    logic [2:0]         cnt_reg;
    logic [2:0]         n_next;

    logic               s_acc;
    logic               m_acc;
    logic [11:0]        limit;
    logic [11:0]        count_inc;
    logic [7:0]         hex_b;
    logic [7:0]         sent;
    logic [7:0]         b;

    assign b         = s_tdata;
    assign s_acc     = s_tvalid && s_tready;
    assign m_acc     = m_tvalid && m_tready;
    assign limit     = (max_payload_reg < CAP) ? max_payload_reg : CAP;
    assign count_inc = count_reg + 12'd1;
    assign hex_b     = dpr_pkg::hex_digit(b);
    assign sent      = high_reg + hex_b;

    // Buffer can take a new list once it is empty or its last word leaves now
    assign s_tready = (cnt_reg == 3'd0) || (cnt_reg == 3'd1 && m_tready);

    // Output side
    assign m_tvalid = (cnt_reg != 3'd0);
    assign m_tdata  = buf_reg[0].value;
    assign m_tuser  = buf_reg[0].kind;
    assign m_tlast  = buf_reg[0].last;

    // Configuration read-back
    assign pready = 1'b1;
    assign prdata = (paddr[2] == dpr_pkg::REG_MAX_PAYLOAD) ? {20'd0, max_payload_reg}
                                                           : 32'd0;

    // Per-byte decode: next state and the list of result words
    always_comb
    begin
        phase_next = phase_reg;
        sum_next   = sum_reg;
        count_next = count_reg;
        seq_next   = seq_reg;
        colon_next = colon_reg;
        high_next  = high_reg;
        n_next     = 3'd0;
        for (int i = 0; i < dpr_pkg::MAX_RESULTS; i++)
        begin
            list_next[i] = '{kind: dpr_pkg::KIND_DROP, value: 8'd0, last: 1'b0};
        end

        case (phase_reg)
            PH_HUNT:
            begin
                if (b == dpr_pkg::CH_START)
                begin
                    sum_next   = 8'd0;
                    count_next = 12'd0;
                    colon_next = 1'b0;
                    seq_next   = 16'd0;
                    if (limit == 12'd0)
                        n_next = 3'd1;           // zero limit: drop at once
                    else
                        phase_next = PH_DATA;
                end
            end
            PH_DATA:
            begin
                if (count_reg >= limit)
                begin
                    // limit lowered under a running packet
                    n_next     = 3'd1;
                    phase_next = PH_HUNT;
                end
                else if (b == dpr_pkg::CH_START)
                begin
                    // restart: report drop, open a fresh packet
                    n_next     = 3'd1;
                    sum_next   = 8'd0;
                    count_next = 12'd0;
                    colon_next = 1'b0;
                    seq_next   = 16'd0;
                    if (limit == 12'd0)
                        phase_next = PH_HUNT;
                    else
                        phase_next = PH_DATA;
                end
                else if (b == dpr_pkg::CH_END)
                begin
                    phase_next = PH_HIGH;
                end
                else
                begin
                    sum_next   = sum_reg + b;
                    count_next = count_inc;
                    if (count_reg == 12'd0)
                        seq_next = {b, seq_reg[7:0]};
                    else if (count_reg == 12'd1)
                        seq_next = {seq_reg[15:8], b};
                    else if (count_reg == 12'd2)
                        colon_next = (b == dpr_pkg::CH_COLON);
                    list_next[0] = '{kind: dpr_pkg::KIND_PAYLOAD, value: b, last: 1'b0};
                    n_next       = 3'd1;
                    if (count_inc >= limit)
                    begin
                        n_next     = 3'd2;       // overlong: drop follows
                        phase_next = PH_HUNT;
                    end
                end
            end
            PH_HIGH:
            begin
                high_next  = {hex_b[3:0], 4'd0};
                phase_next = PH_LOW;
            end
            default:
            begin
                phase_next = PH_HUNT;
                if (sent != sum_reg)
                begin
                    list_next[0] = '{kind: dpr_pkg::KIND_REPLY, value: dpr_pkg::CH_NAK,
                                     last: 1'b0};
                    list_next[1] = '{kind: dpr_pkg::KIND_REJECT, value: 8'd0, last: 1'b0};
                    n_next       = 3'd2;
                end
                else if (colon_reg && count_reg >= 12'd3)
                begin
                    list_next[0] = '{kind: dpr_pkg::KIND_REPLY, value: dpr_pkg::CH_ACK,
                                     last: 1'b0};
                    list_next[1] = '{kind: dpr_pkg::KIND_REPLY, value: seq_reg[15:8],
                                     last: 1'b0};
                    list_next[2] = '{kind: dpr_pkg::KIND_REPLY, value: seq_reg[7:0],
                                     last: 1'b0};
                    list_next[3] = '{kind: dpr_pkg::KIND_ACCEPT,
                                     value: dpr_pkg::SEQ_OFFSET, last: 1'b0};
                    n_next       = 3'd4;
                end
                else
                begin
                    list_next[0] = '{kind: dpr_pkg::KIND_REPLY, value: dpr_pkg::CH_ACK,
                                     last: 1'b0};
                    list_next[1] = '{kind: dpr_pkg::KIND_ACCEPT, value: 8'd0, last: 1'b0};
                    n_next       = 3'd2;
                end
            end
        endcase

        // mark the final word of this byte
        for (int i = 0; i < dpr_pkg::MAX_RESULTS; i++)
        begin
            list_next[i].last = (3'(i + 1) == n_next);
        end
    end

    // Receiver state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            sum_reg   <= 8'd0;
            count_reg <= 12'd0;
            seq_reg   <= 16'd0;
            colon_reg <= 1'b0;
            high_reg  <= 8'd0;
        end
        else if (s_acc)
        begin
            phase_reg <= phase_next;
            sum_reg   <= sum_next;
            count_reg <= count_next;
            seq_reg   <= seq_next;
            colon_reg <= colon_next;
            high_reg  <= high_next;
        end
    end

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_payload_reg <= 12'd4095;
        else if (psel && penable && pwrite && pready
                 && paddr[2] == dpr_pkg::REG_MAX_PAYLOAD)
            max_payload_reg <= pwdata[11:0];
    end

    // Result buffer: loaded whole on accept, shifted down as words leave
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 3'd0;
        else if (s_acc)
            cnt_reg <= n_next;
        else if (m_acc)
            cnt_reg <= cnt_reg - 3'd1;
    end

    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            for (int i = 0; i < dpr_pkg::MAX_RESULTS; i++)
                buf_reg[i] <= list_next[i];
        end
        else if (m_acc)
        begin
            for (int i = 0; i < dpr_pkg::MAX_RESULTS - 1; i++)
                buf_reg[i] <= buf_reg[i + 1];
        end
    end

    // Checks
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 3'(dpr_pkg::MAX_RESULTS))
        else $error("result count out of range");

    a_last_alone: assert property (@(posedge clk) disable iff (!rst_n)
        (m_acc && m_tlast) |-> (cnt_reg == 3'd1))
        else $error("final word leaves with words still queued behind it");

    a_high_to_low: assert property (@(posedge clk) disable iff (!rst_n)
        (s_acc && phase_reg == PH_HIGH) |=> (phase_reg == PH_LOW))
        else $error("high digit not followed by low digit");

    a_verdict_words: assert property (@(posedge clk) disable iff (!rst_n)
        (s_acc && phase_reg == PH_LOW) |=> (cnt_reg >= 3'd2 && phase_reg == PH_HUNT))
        else $error("checksum verdict missing");

endmodule

### sim/debug_packet_receiver_unit_tb.sv
// ----------------------------------------------------------------------------
// debug_packet_receiver_unit_tb: self-checking bench for the packet receiver
// Streams link bytes into the receiver with random gaps and result stalls,
// predicts every result word from its own model of the framing, checksum and
// sequence ID echo, and compares each accepted word field by field. The
// payload limit is reprogrammed between traffic phases, from 0 up to 4095.
// ----------------------------------------------------------------------------
module debug_packet_receiver_unit_tb;

    localparam int         CLK_HALF         = 6;
    localparam int         RESET_CYCLES     = 10;
    localparam int         SETTLE_CYCLES    = 8;
    localparam int         CYCLE_LIMIT      = 400000;
    localparam int         BUF_BYTES        = 4096;
    localparam int         MAX_GAP          = 10;
    localparam logic [2:0] ADDR_MAX_PAYLOAD = {2'b00, dpr_pkg::REG_MAX_PAYLOAD} << 2;
    localparam logic [2:0] ADDR_UNMAPPED    = 3'd4;

    typedef enum logic [1:0] {
        RX_HUNT,
        RX_DATA,
        RX_SUM_HI,
        RX_SUM_LO
    } rx_phase_t;

    logic        clk     = 1'b0;
    logic        rst_n   = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = 3'd0;
    logic [31:0] pwdata  = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    // Receiver model state
    rx_phase_t   rx_phase    = RX_HUNT;
    logic [7:0]  rx_sum      = 8'd0;
    logic [11:0] rx_count    = 12'd0;
    logic [15:0] rx_seq      = 16'd0;
    logic        rx_colon    = 1'b0;
    logic [7:0]  rx_sent_hi  = 8'd0;
    logic [11:0] payload_cap = 12'd4095;

    dpr_pkg::res_t expected_words[$];
    logic [7:0]  link_bytes[$];
    int          bytes_owed   = 0;
    int          bytes_issued = 0;
    int          mismatches   = 0;
    int          cycle_count  = 0;
    int          out_hold     = 0;
    int          in_gap       = 0;
    bit          steady       = 1'b0;

    debug_packet_receiver_unit #(
        .BUFFER_BYTES (BUF_BYTES)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #CLK_HALF clk = ~clk;

    task automatic report(input string msg);
        $display("ERROR @%0d: %s", cycle_count, msg);
        mismatches++;
    endtask

    function automatic int draw_gap();
        return steady ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    // ------------------------------------------------------------------
    // Receiver model
    // ------------------------------------------------------------------
    function automatic logic [11:0] active_limit();
        return (payload_cap < 12'(BUF_BYTES - 1)) ? payload_cap : 12'(BUF_BYTES - 1);
    endfunction

    // Hex character to nibble; a non-hex character counts as -1
    function automatic logic [7:0] digit_value(input logic [7:0] c);
        logic [7:0] v;
        v = 8'hFF;
        if (c >= "0" && c <= "9")
            v = c - "0";
        else if (c >= "a" && c <= "f")
            v = c - "a" + 8'd10;
        else if (c >= "A" && c <= "F")
            v = c - "A" + 8'd10;
        return v;
    endfunction

    function automatic void add_word(input logic [2:0] kind, input logic [7:0] value);
        dpr_pkg::res_t w;
        w.kind  = kind;
        w.value = value;
        w.last  = 1'b0;
        expected_words.push_back(w);
    endfunction

    function automatic void open_packet();
        rx_sum   = 8'd0;
        rx_count = 12'd0;
        rx_colon = 1'b0;
        rx_seq   = 16'd0;
        if (active_limit() == 12'd0)
            rx_phase = RX_HUNT;
        else
            rx_phase = RX_DATA;
    endfunction

    // Work out the result words caused by one link byte
    function automatic void predict_link_byte(input logic [7:0] b);
        int            before_n;
        logic [7:0]    sent;
        dpr_pkg::res_t tail;
        before_n = expected_words.size();
        case (rx_phase)
            RX_HUNT:
                if (b == dpr_pkg::CH_START)
                begin
                    open_packet();
                    if (rx_phase == RX_HUNT)
                        add_word(dpr_pkg::KIND_DROP, 8'd0);
                end
            RX_DATA:
                if (rx_count >= active_limit())
                begin
                    // limit lowered under a packet in flight
                    add_word(dpr_pkg::KIND_DROP, 8'd0);
                    rx_phase = RX_HUNT;
                end
                else if (b == dpr_pkg::CH_START)
                begin
                    add_word(dpr_pkg::KIND_DROP, 8'd0);
                    open_packet();
                end
                else if (b == dpr_pkg::CH_END)
                begin
                    rx_phase = RX_SUM_HI;
                end
                else
                begin
                    rx_sum = rx_sum + b;
                    case (rx_count)
                        12'd0:   rx_seq[15:8] = b;
                        12'd1:   rx_seq[7:0]  = b;
                        12'd2:   rx_colon     = (b == dpr_pkg::CH_COLON);
                        default: ;
                    endcase
                    rx_count = rx_count + 12'd1;
                    add_word(dpr_pkg::KIND_PAYLOAD, b);
                    if (rx_count >= active_limit())
                    begin
                        add_word(dpr_pkg::KIND_DROP, 8'd0);
                        rx_phase = RX_HUNT;
                    end
                end
            RX_SUM_HI:
            begin
                rx_sent_hi = digit_value(b) << 4;
                rx_phase   = RX_SUM_LO;
            end
            default:
            begin
                sent = rx_sent_hi + digit_value(b);
                if (sent != rx_sum)
                begin
                    add_word(dpr_pkg::KIND_REPLY, dpr_pkg::CH_NAK);
                    add_word(dpr_pkg::KIND_REJECT, 8'd0);
                end
                else
                begin
                    add_word(dpr_pkg::KIND_REPLY, dpr_pkg::CH_ACK);
                    if (rx_colon && rx_count >= 12'd3)
                    begin
                        add_word(dpr_pkg::KIND_REPLY, rx_seq[15:8]);
                        add_word(dpr_pkg::KIND_REPLY, rx_seq[7:0]);
                        add_word(dpr_pkg::KIND_ACCEPT, dpr_pkg::SEQ_OFFSET);
                    end
                    else
                    begin
                        add_word(dpr_pkg::KIND_ACCEPT, 8'd0);
                    end
                end
                rx_phase = RX_HUNT;
            end
        endcase
        // flag the final word of this byte
        if (expected_words.size() > before_n)
        begin
            tail      = expected_words.pop_back();
            tail.last = 1'b1;
            expected_words.push_back(tail);
        end
    endfunction

    // ------------------------------------------------------------------
    // Byte driver
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            in_gap   <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                predict_link_byte(s_tdata);
                bytes_owed--;
            end
            if (!s_tvalid || s_tready)
            begin
                if (in_gap > 0)
                begin
                    in_gap   <= in_gap - 1;
                    s_tvalid <= 1'b0;
                end
                else if (link_bytes.size() > 0)
                begin
                    s_tdata  <= link_bytes.pop_front();
                    s_tvalid <= 1'b1;
                    in_gap   <= draw_gap();
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        dpr_pkg::res_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            out_hold = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_words.size() == 0)
                    report($sformatf("unexpected word kind %0d value %02h last %0b",
                                     m_tuser, m_tdata, m_tlast));
                else
                begin
                    want = expected_words.pop_front();
                    if (m_tuser !== want.kind || m_tdata !== want.value ||
                        m_tlast !== want.last)
                        report($sformatf({"word kind %0d value %02h last %0b,",
                                          " wanted %0d %02h %0b"},
                                         m_tuser, m_tdata, m_tlast,
                                         want.kind, want.value, want.last));
                end
                out_hold = draw_gap();
            end
            if (out_hold > 0)
            begin
                out_hold--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL debug_packet_receiver_unit");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (addr == ADDR_MAX_PAYLOAD)
            payload_cap = data[11:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_check_limit();
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_MAX_PAYLOAD;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== {20'd0, payload_cap})
            report($sformatf("max_payload read %08h, wanted %03h", prdata, payload_cap));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic push_byte(input logic [7:0] b);
        link_bytes.push_back(b);
        bytes_owed++;
        bytes_issued++;
    endtask

    // Wait for every expected word, then let the block settle
    task automatic wait_idle();
        while (bytes_owed > 0 || expected_words.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
        if (n < 4'd10)
            return 8'h30 + 8'(n);
        return (upper ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
    endfunction

    function automatic logic [7:0] payload_char();
        logic [7:0] c;
        do c = 8'($urandom); while (c == dpr_pkg::CH_START || c == dpr_pkg::CH_END);
        return c;
    endfunction

    // $<body>#<hh>, checksum right or deliberately wrong
    task automatic push_packet(input logic [7:0] body[$], input bit good_sum);
        logic [7:0] sum;
        bit         upper;
        sum = 8'd0;
        push_byte(dpr_pkg::CH_START);
        foreach (body[i])
        begin
            push_byte(body[i]);
            sum = sum + body[i];
        end
        push_byte(dpr_pkg::CH_END);
        if (!good_sum)
            sum = sum + 8'($urandom_range(1, 255));
        upper = 1'($urandom_range(0, 1));
        push_byte(hex_char(sum[7:4], upper));
        push_byte(hex_char(sum[3:0], upper));
    endtask

    // One limit setting and a burst of mixed traffic
    task automatic run_phase(input logic [11:0] cap, input int budget);
        logic [7:0] body[$];
        int         target;
        int         pick;
        int         len;
        int         n;
        apb_write(ADDR_MAX_PAYLOAD, {20'd0, cap});
        apb_check_limit();
        steady = ($urandom_range(0, 3) == 0);
        target = bytes_issued + budget;
        while (bytes_issued < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 65)
            begin
                // well-formed packet, sometimes with a sequence ID or a wrong checksum
                body.delete();
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40)
                                                  : $urandom_range(0, 8);
                if (len >= 3 && $urandom_range(0, 2) == 0)
                begin
                    body = {payload_char(), payload_char(), dpr_pkg::CH_COLON};
                    len  = len - 3;
                end
                repeat (len) body.push_back(payload_char());
                repeat ($urandom_range(0, 2)) push_byte(payload_char());
                push_packet(body, $urandom_range(0, 4) != 0);
            end
            else if (pick < 77)
            begin
                // line noise, not counted towards the budget
                n = $urandom_range(1, 6);
                repeat (n) push_byte(8'($urandom));
                target = target + n;
            end
            else if (pick < 87)
            begin
                // abandoned packet: the next start marker restarts it
                push_byte(dpr_pkg::CH_START);
                repeat ($urandom_range(0, 5)) push_byte(payload_char());
            end
            else
            begin
                // checksum field with arbitrary characters
                push_byte(dpr_pkg::CH_START);
                repeat ($urandom_range(0, 4)) push_byte(payload_char());
                push_byte(dpr_pkg::CH_END);
                repeat (2)
                    push_byte(($urandom_range(0, 3) == 0) ? dpr_pkg::CH_START
                                                          : 8'($urandom));
            end
        end
        wait_idle();
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        logic [7:0] body[$];
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        apb_check_limit();

        // Directed: ignored bytes while hunting
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(dpr_pkg::CH_END);
        // empty payload
        body = {};
        push_packet(body, 1'b1);
        // sequence ID echo
        body = {8'h31, 8'h61, dpr_pkg::CH_COLON};
        push_packet(body, 1'b1);
        // restart inside the payload
        push_byte(dpr_pkg::CH_START);
        push_byte(8'h71);
        // two-byte payload, no echo
        body = {8'h61, dpr_pkg::CH_COLON};
        push_packet(body, 1'b1);
        // start marker and a non-hex character as checksum digits
        push_byte(dpr_pkg::CH_START);
        push_byte(dpr_pkg::CH_END);
        push_byte(dpr_pkg::CH_START);
        push_byte(8'h7A);
        // checksum mismatch
        body = {8'h6D};
        push_packet(body, 1'b0);
        wait_idle();

        // Limit lowered under a packet in flight
        push_byte(dpr_pkg::CH_START);
        repeat (4) push_byte(payload_char());
        wait_idle();
        apb_write(ADDR_MAX_PAYLOAD, 32'd2);
        apb_write(ADDR_UNMAPPED, 32'd5);
        apb_check_limit();
        push_byte(8'h65);
        wait_idle();

        // Random traffic over a spread of limits
        run_phase(12'd0, 20);
        run_phase(12'd1, 40);
        run_phase(12'd2, 40);
        run_phase(12'd3, 40);
        run_phase(12'($urandom_range(4, 24)), 60);
        run_phase(12'd4095, 60);
        run_phase(12'($urandom_range(3, 60)), 60);
        run_phase(12'($urandom_range(100, 4094)), 30);
        run_phase(12'd4095, 30);

        if (mismatches == 0)
            $display("PASS debug_packet_receiver_unit");
        else
            $display("FAIL debug_packet_receiver_unit");
        $finish;
    end

endmodule
